FILE: design/kle_pkg.sv
// shared constants and types for the keystroke line editor
package kle_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [7:0] KEY_LEFT  = 8'h3C;
    localparam logic [7:0] KEY_RIGHT = 8'h3E;
    localparam logic [7:0] KEY_BACK  = 8'h2D;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last;
        logic       empty_line;
        logic       overflowed;
    } kle_result_t;

endpackage

FILE: design/kle_stack_ram.sv
// simple dual-port synchronous ram used for one text stack
module kle_stack_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: design/kle_out_stage.sv
// output register for result transactions
module kle_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  kle_pkg::kle_result_t load_data,
    output logic                can_load,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [7:0]          m_axis_tdata,   // text_byte
    output logic                m_axis_tlast,   // last
    output logic [1:0]          m_axis_tuser    // empty_line, overflowed
);

    logic                 valid_reg;
    kle_pkg::kle_result_t data_reg;

    assign can_load = !valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && can_load)
        begin
            data_reg <= load_data;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg.text_byte;
    assign m_axis_tlast  = data_reg.last;
    assign m_axis_tuser  = {data_reg.overflowed, data_reg.empty_line};

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> can_load)
        else $error("result loaded while output register busy");

endmodule

FILE: design/keystroke_line_editor.sv
// keystroke line editor top level: two stack rams, edit and drain sequencer
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid/s_axis_tready    tdata = key, tlast = line_end
//  m_axis    out  m_axis_tvalid/m_axis_tready    tdata = text_byte, tlast = last,
//                                                tuser = {overflowed, empty_line}
//
//  insert and backspace finish in ST_IDLE; '<' and '>' read the ram, then write back
//  a line end enters ST_DRAIN_START, then each emitted byte is a ram read, then an output load
//  reset clears counts, overflow flag and sequencer; the stack rams are not cleared
//  input is taken only while the sequencer is idle; output stalls hold the drain
module keystroke_line_editor (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,    // key
    input  logic       s_axis_tlast,    // line_end
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,    // text_byte
    output logic       m_axis_tlast,    // last
    output logic [1:0] m_axis_tuser     // empty_line, overflowed
);

    localparam int AW = kle_pkg::ADDR_W;
    localparam int CW = kle_pkg::CNT_W;
    localparam logic [CW:0] CAP_TOTAL = (CW+1)'(kle_pkg::CAPACITY);
    localparam logic [CW-1:0] CAP_CNT = CW'(kle_pkg::CAPACITY);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOVE_L,
        ST_MOVE_R,
        ST_DRAIN_START,
        ST_DRAIN_RD,
        ST_DRAIN_WAIT,
        ST_EMPTY
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] lc_reg, lc_next;
    logic [CW-1:0] rc_reg, rc_next;
    logic          ovf_reg, ovf_next;
    logic          pend_reg, pend_next;
    logic          side_reg, side_next;     // 0 left stack, 1 right stack
    logic [AW-1:0] idx_reg, idx_next;

    logic          left_we, right_we, left_re, right_re;
    logic [AW-1:0] left_waddr, right_waddr, left_raddr, right_raddr;
    logic [7:0]    left_wdata, right_wdata, left_rdata, right_rdata;

    logic                 out_load, can_load;
    kle_pkg::kle_result_t out_data;

    logic          accept;
    logic [CW:0]   total;
    logic [CW-1:0] lc_dec, rc_dec;
    logic          last_byte;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept = s_axis_tvalid && s_axis_tready;
    assign total  = {1'b0, lc_reg} + {1'b0, rc_reg};
    assign lc_dec = lc_reg - CW'(1);
    assign rc_dec = rc_reg - CW'(1);
    assign last_byte = side_reg ? (idx_reg == '0)
                                : (({1'b0, idx_reg} == lc_dec) && (rc_reg == '0));

    always_comb
    begin
        state_next  = state_reg;
        lc_next     = lc_reg;
        rc_next     = rc_reg;
        ovf_next    = ovf_reg;
        pend_next   = pend_reg;
        side_next   = side_reg;
        idx_next    = idx_reg;
        left_we     = 1'b0;
        left_waddr  = lc_reg[AW-1:0];
        left_wdata  = s_axis_tdata;
        left_re     = 1'b0;
        left_raddr  = idx_reg;
        right_we    = 1'b0;
        right_waddr = rc_reg[AW-1:0];
        right_wdata = left_rdata;
        right_re    = 1'b0;
        right_raddr = idx_reg;
        out_load    = 1'b0;
        out_data    = '{text_byte: side_reg ? right_rdata : left_rdata,
                        last: last_byte, empty_line: 1'b0, overflowed: ovf_reg};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    pend_next  = s_axis_tlast;
                    state_next = s_axis_tlast ? ST_DRAIN_START : ST_IDLE;
                    unique case (s_axis_tdata)
                        kle_pkg::KEY_LEFT:
                        begin
                            if ((lc_reg != '0) && (rc_reg < CAP_CNT))
                            begin
                                left_re    = 1'b1;
                                left_raddr = lc_dec[AW-1:0];
                                state_next = ST_MOVE_L;
                            end
                        end
                        kle_pkg::KEY_RIGHT:
                        begin
                            if ((rc_reg != '0) && (lc_reg < CAP_CNT))
                            begin
                                right_re    = 1'b1;
                                right_raddr = rc_dec[AW-1:0];
                                state_next  = ST_MOVE_R;
                            end
                        end
                        kle_pkg::KEY_BACK:
                        begin
                            if (lc_reg != '0)
                            begin
                                lc_next = lc_dec;
                            end
                        end
                        default:
                        begin
                            if (total < CAP_TOTAL)
                            begin
                                left_we = 1'b1;
                                lc_next = lc_reg + CW'(1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_MOVE_L:
            begin
                // top of left stack arrives, push it on the right stack
                right_we   = 1'b1;
                lc_next    = lc_dec;
                rc_next    = rc_reg + CW'(1);
                state_next = pend_reg ? ST_DRAIN_START : ST_IDLE;
            end
            ST_MOVE_R:
            begin
                left_we    = 1'b1;
                left_wdata = right_rdata;
                lc_next    = lc_reg + CW'(1);
                rc_next    = rc_dec;
                state_next = pend_reg ? ST_DRAIN_START : ST_IDLE;
            end
            ST_DRAIN_START:
            begin
                if (total == '0)
                begin
                    state_next = ST_EMPTY;
                end
                else if (lc_reg != '0)
                begin
                    side_next  = 1'b0;
                    idx_next   = '0;
                    state_next = ST_DRAIN_RD;
                end
                else
                begin
                    side_next  = 1'b1;
                    idx_next   = rc_dec[AW-1:0];
                    state_next = ST_DRAIN_RD;
                end
            end
            ST_DRAIN_RD:
            begin
                left_re    = !side_reg;
                right_re   = side_reg;
                state_next = ST_DRAIN_WAIT;
            end
            ST_DRAIN_WAIT:
            begin
                if (can_load)
                begin
                    out_load = 1'b1;
                    if (last_byte)
                    begin
                        lc_next    = '0;
                        rc_next    = '0;
                        ovf_next   = 1'b0;
                        pend_next  = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_DRAIN_RD;
                        if (side_reg)
                        begin
                            idx_next = idx_reg - AW'(1);
                        end
                        else if ({1'b0, idx_reg} == lc_dec)
                        begin
                            // left text done, continue from the top of the right stack
                            side_next = 1'b1;
                            idx_next  = rc_dec[AW-1:0];
                        end
                        else
                        begin
                            idx_next = idx_reg + AW'(1);
                        end
                    end
                end
            end
            ST_EMPTY:
            begin
                out_data = '{text_byte: 8'h00, last: 1'b1, empty_line: 1'b1,
                             overflowed: ovf_reg};
                if (can_load)
                begin
                    out_load   = 1'b1;
                    ovf_next   = 1'b0;
                    pend_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            lc_reg    <= '0;
            rc_reg    <= '0;
            ovf_reg   <= 1'b0;
            pend_reg  <= 1'b0;
            side_reg  <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            lc_reg    <= lc_next;
            rc_reg    <= rc_next;
            ovf_reg   <= ovf_next;
            pend_reg  <= pend_next;
            side_reg  <= side_next;
            idx_reg   <= idx_next;
        end
    end

    kle_stack_ram #(.DEPTH(kle_pkg::CAPACITY), .WIDTH(8)) u_left_ram (
        .clk   (clk),
        .we    (left_we),
        .waddr (left_waddr),
        .wdata (left_wdata),
        .re    (left_re),
        .raddr (left_raddr),
        .rdata (left_rdata)
    );

    kle_stack_ram #(.DEPTH(kle_pkg::CAPACITY), .WIDTH(8)) u_right_ram (
        .clk   (clk),
        .we    (right_we),
        .waddr (right_waddr),
        .wdata (right_wdata),
        .re    (right_re),
        .raddr (right_raddr),
        .rdata (right_rdata)
    );

    kle_out_stage u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (out_load),
        .load_data     (out_data),
        .can_load      (can_load),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total <= CAP_TOTAL)
        else $error("stack counts exceed capacity");

    a_move_source: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MOVE_L || state_reg == ST_MOVE_R) |->
            ($past(accept) && (lc_reg + rc_reg) != '0))
        else $error("cursor move without a pending read");

    a_drain_index: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DRAIN_RD || state_reg == ST_DRAIN_WAIT) && !side_reg) |->
            ({1'b0, idx_reg} < lc_reg))
        else $error("drain index past left text");

    a_drain_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && out_data.last) |=> (lc_reg == '0 && rc_reg == '0 && !ovf_reg))
        else $error("buffer not cleared after line emitted");

endmodule

FILE: verif/keystroke_line_editor_test.sv
// self-checking testbench for the keystroke line editor: directed table, a capacity overflow line, then random lines
`timescale 1ns / 1ps

module keystroke_line_editor_test;

    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic [7:0]           key;
        logic                 line_end;
        logic                 typed;
        kle_pkg::kle_result_t want;
    } keystroke_row_t;

    logic       clk;
    logic       rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;    // key
    logic       s_axis_tlast;    // line_end
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;    // text_byte
    logic       m_axis_tlast;    // last
    logic [1:0] m_axis_tuser;    // empty_line, overflowed

    // predictor state
    logic [7:0]                left_chars [kle_pkg::CAPACITY];
    logic [7:0]                right_chars [kle_pkg::CAPACITY];
    logic [kle_pkg::CNT_W-1:0] left_n;
    logic [kle_pkg::CNT_W-1:0] right_n;
    logic                      dropped;

    kle_pkg::kle_result_t line_out[$];
    kle_pkg::kle_result_t expected_text[$];
    keystroke_row_t       script[$];

    int  mismatches;
    int  keys_sent;
    int  lines_done;
    int  results_checked;
    int  overflow_lines;
    int  empty_lines;
    int  hold_left;
    int  stall_req;
    int  stall_seen;
    logic no_idle;

    keystroke_line_editor dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 clk = ~clk;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    // applies one keystroke to the predicted buffer, fills line_out on a line end
    task automatic edit_and_emit(input logic [7:0] k, input logic le);
        kle_pkg::kle_result_t r;
        line_out.delete();
        if (k == kle_pkg::KEY_LEFT)
        begin
            if (left_n > 0 && right_n < kle_pkg::CAPACITY)
            begin
                left_n--;
                right_chars[right_n] = left_chars[left_n];
                right_n++;
            end
        end
        else if (k == kle_pkg::KEY_RIGHT)
        begin
            if (right_n > 0 && left_n < kle_pkg::CAPACITY)
            begin
                right_n--;
                left_chars[left_n] = right_chars[right_n];
                left_n++;
            end
        end
        else if (k == kle_pkg::KEY_BACK)
        begin
            if (left_n > 0)
                left_n--;
        end
        else if (left_n + right_n < kle_pkg::CAPACITY)
        begin
            left_chars[left_n] = k;
            left_n++;
        end
        else
        begin
            dropped = 1'b1;
        end

        if (le)
        begin
            if (left_n + right_n == 0)
            begin
                r = '{text_byte: 8'h00, last: 1'b1, empty_line: 1'b1, overflowed: dropped};
                line_out.push_back(r);
                empty_lines++;
            end
            else
            begin
                for (int i = 0; i < left_n; i++)
                begin
                    r = '{text_byte: left_chars[i], last: 1'b0, empty_line: 1'b0,
                          overflowed: dropped};
                    line_out.push_back(r);
                end
                for (int i = right_n - 1; i >= 0; i--)
                begin
                    r = '{text_byte: right_chars[i], last: 1'b0, empty_line: 1'b0,
                          overflowed: dropped};
                    line_out.push_back(r);
                end
                r = line_out[line_out.size() - 1];
                r.last = 1'b1;
                line_out[line_out.size() - 1] = r;
            end
            if (dropped)
                overflow_lines++;
            left_n = '0;
            right_n = '0;
            dropped = 1'b0;
            lines_done++;
        end
    endtask

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic send_key(input logic [7:0] k, input logic le,
                            input logic typed = 1'b0,
                            input kle_pkg::kle_result_t want = '0);
        if (!no_idle && $urandom_range(0, 99) < 33)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= k;
        s_axis_tlast  <= le;
        do
            @(posedge clk);
        while (!s_axis_tready);
        edit_and_emit(k, le);
        if (typed)
            expected_text.push_back(want);
        else
            foreach (line_out[i])
                expected_text.push_back(line_out[i]);
        keys_sent++;
        @(negedge clk);
    endtask

    task automatic add_row(input logic [7:0] k, input logic le,
                           input logic typed = 1'b0,
                           input kle_pkg::kle_result_t want = '0);
        keystroke_row_t row;
        row.key = k;
        row.line_end = le;
        row.typed = typed;
        row.want = want;
        script.push_back(row);
    endtask

    function automatic logic [7:0] random_text_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == kle_pkg::KEY_LEFT || b == kle_pkg::KEY_RIGHT || b == kle_pkg::KEY_BACK);
        return b;
    endfunction

    function automatic logic [7:0] random_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12)
            return kle_pkg::KEY_LEFT;
        else if (r < 24)
            return kle_pkg::KEY_RIGHT;
        else if (r < 35)
            return kle_pkg::KEY_BACK;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    // receiver: random backpressure, plus one long hold on request
    always @(negedge clk)
    begin
        if (stall_req != stall_seen)
        begin
            stall_seen    <= stall_req;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 33);
        end
    end

    always @(posedge clk)
    begin
        kle_pkg::kle_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_text.size() == 0)
            begin
                report_mismatch($sformatf("result %02h with nothing expected", m_axis_tdata));
            end
            else
            begin
                want = expected_text.pop_front();
                if (!want.empty_line && m_axis_tdata !== want.text_byte)
                    report_mismatch($sformatf("text_byte %02h, expected %02h",
                                              m_axis_tdata, want.text_byte));
                if (m_axis_tlast !== want.last)
                    report_mismatch($sformatf("last %b, expected %b",
                                              m_axis_tlast, want.last));
                if (m_axis_tuser[0] !== want.empty_line)
                    report_mismatch($sformatf("empty_line %b, expected %b",
                                              m_axis_tuser[0], want.empty_line));
                if (m_axis_tuser[1] !== want.overflowed)
                    report_mismatch($sformatf("overflowed %b, expected %b",
                                              m_axis_tuser[1], want.overflowed));
                results_checked++;
            end
        end
    end

    initial
    begin
        #1000000;
        $display("timeout with %0d results still expected", expected_text.size());
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int random_keys;
        int len;
        clk = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 8'h00;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        no_idle = 1'b0;
        hold_left = 0;
        stall_req = 0;
        stall_seen = 0;
        left_n = '0;
        right_n = '0;
        dropped = 1'b0;

        // empty lines: backspace, left and right with nothing in the buffer
        add_row(kle_pkg::KEY_BACK,  1'b1, 1'b1,
                kle_pkg::kle_result_t'({8'h00, 1'b1, 1'b1, 1'b0}));
        add_row(kle_pkg::KEY_LEFT,  1'b1, 1'b1,
                kle_pkg::kle_result_t'({8'h00, 1'b1, 1'b1, 1'b0}));
        add_row(kle_pkg::KEY_RIGHT, 1'b1, 1'b1,
                kle_pkg::kle_result_t'({8'h00, 1'b1, 1'b1, 1'b0}));
        // one-character lines at the byte extremes
        add_row(8'h00, 1'b1, 1'b1, kle_pkg::kle_result_t'({8'h00, 1'b1, 1'b0, 1'b0}));
        add_row(8'hFF, 1'b1, 1'b1, kle_pkg::kle_result_t'({8'hFF, 1'b1, 1'b0, 1'b0}));
        // cursor walks past both ends of a short line
        add_row(8'h61, 1'b0);
        add_row(8'h62, 1'b0);
        add_row(kle_pkg::KEY_LEFT, 1'b0);
        add_row(kle_pkg::KEY_LEFT, 1'b0);
        add_row(kle_pkg::KEY_LEFT, 1'b0);
        add_row(8'h63, 1'b0);
        add_row(kle_pkg::KEY_RIGHT, 1'b0);
        add_row(kle_pkg::KEY_RIGHT, 1'b0);
        add_row(kle_pkg::KEY_RIGHT, 1'b0);
        add_row(kle_pkg::KEY_RIGHT, 1'b0);
        add_row(kle_pkg::KEY_BACK, 1'b0);
        add_row(8'h78, 1'b1);
        // backspace runs into the line start
        add_row(8'h71, 1'b0);
        add_row(kle_pkg::KEY_BACK, 1'b0);
        add_row(kle_pkg::KEY_BACK, 1'b0);
        add_row(8'h55, 1'b1);
        add_row(8'hAA, 1'b0);
        add_row(kle_pkg::KEY_LEFT, 1'b1);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (script[i])
            send_key(script[i].key, script[i].line_end, script[i].typed, script[i].want);

        // let the block drain completely before the long line
        s_axis_tvalid <= 1'b0;
        while (expected_text.size() != 0)
            @(negedge clk);

        // fill to capacity with cursor moves and backspaces mixed in, then overflow
        while (left_n + right_n < kle_pkg::CAPACITY)
            send_key(($urandom_range(0, 99) < 20) ? random_key() : random_text_byte(), 1'b0);
        send_key(random_text_byte(), 1'b0);
        send_key(kle_pkg::KEY_LEFT, 1'b0);
        send_key(random_text_byte(), 1'b0);
        send_key(kle_pkg::KEY_RIGHT, 1'b0);
        // receiver holds off while the full line drains, so the following keys wait at the input
        stall_req <= stall_req + 1;
        send_key(random_text_byte(), 1'b1);

        random_keys = 0;
        while (random_keys < 36)
        begin
            no_idle <= (random_keys >= 8 && random_keys < 30);
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
                send_key(random_key(), i == len - 1);
            random_keys += len;
        end
        no_idle <= 1'b0;
        s_axis_tvalid <= 1'b0;

        while (expected_text.size() != 0)
            @(negedge clk);
        repeat (2 * kle_pkg::CAPACITY + 20) @(negedge clk);
        if (expected_text.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_text.size()));

        $display("sent %0d keystrokes in %0d lines, checked %0d output bytes",
                 keys_sent, lines_done, results_checked);
        $display("lines with overflow: %0d, empty lines: %0d, mismatches: %0d",
                 overflow_lines, empty_lines, mismatches);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
